// ===== rtl/qwss_pkg.sv =====
// ----------------------------------------------------------------------------
// Quoted word splitter package
// Shared types and constants for the tokenizer front end, queue and back end.
// ----------------------------------------------------------------------------
package qwss_pkg;

  localparam int unsigned MaxSeparators = 8;
  localparam int unsigned SepBytesW     = 64;
  localparam int unsigned SepCountW     = 4;

  localparam logic [7:0] QuoteByte     = 8'h22;
  localparam logic [7:0] BackslashByte = 8'h5C;
  localparam logic [7:0] SpaceByte     = 8'h20;
  localparam logic [7:0] TabByte       = 8'h09;
  localparam logic [7:0] CrByte        = 8'h0D;
  localparam logic [7:0] DelByte       = 8'h7F;

  typedef enum logic [1:0] {
    KindAppend = 2'd0,
    KindClose  = 2'd1,
    KindSep    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CfgSepBytes  = 2'd0,
    CfgSepCount  = 2'd1,
    CfgKeepEmpty = 2'd2
  } cfg_idx_e;

  // One queue entry: an optional close ahead of the main result.
  typedef struct packed {
    logic       close_first;
    kind_e      kind;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/qwss_front.sv =====
// ----------------------------------------------------------------------------
// Quoted word splitter front end
// Classifies each input byte, keeps parse state and pushes queue entries.
// ----------------------------------------------------------------------------
module qwss_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [qwss_pkg::SepBytesW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           in_end_i,
  input  qwss_pkg::queue_status_t        q_status_i,
  output logic                           push_o,
  output qwss_pkg::entry_t               push_entry_o
);
  import qwss_pkg::*;

  logic [SepBytesW-1:0] sep_bytes_q;
  logic [SepCountW-1:0] sep_count_q;
  logic                 keep_empty_q;

  logic started_q, started_d;
  logic inq_q, inq_d;
  logic esc_q, esc_d;
  logic dead_q, dead_d;
  logic has_q, has_d;

  logic                 accept;
  logic                 is_ws;
  logic                 is_ctrl;
  logic                 is_sep;
  logic                 emit_close;
  logic [SepCountW-1:0] sep_lim;
  logic                 push;
  entry_t               entry;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_bytes_q  <= '0;
      sep_count_q  <= '0;
      keep_empty_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSepBytes:  sep_bytes_q  <= cfg_wdata_i;
        CfgSepCount:  sep_count_q  <= cfg_wdata_i[SepCountW-1:0];
        CfgKeepEmpty: keep_empty_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !q_status_i.full;

  assign is_ws   = (in_byte_i == SpaceByte) || (in_byte_i >= TabByte && in_byte_i <= CrByte);
  assign is_ctrl = (in_byte_i < SpaceByte) || (in_byte_i == DelByte);
  assign sep_lim = (sep_count_q > SepCountW'(MaxSeparators)) ?
                   SepCountW'(MaxSeparators) : sep_count_q;
  assign emit_close = keep_empty_q || has_q;

  // Compare against every separator lane in parallel
  always_comb begin
    is_sep = 1'b0;
    for (int i = 0; i < MaxSeparators; i++) begin
      if ((SepCountW'(i) < sep_lim) && (sep_bytes_q[8*i +: 8] == in_byte_i)) begin
        is_sep = 1'b1;
      end
    end
  end

  always_comb begin
    started_d = started_q;
    inq_d     = inq_q;
    esc_d     = esc_q;
    dead_d    = dead_q;
    has_d     = has_q;
    push      = 1'b0;
    entry     = '{close_first: 1'b0, kind: KindAppend, data: in_byte_i};

    if (in_end_i) begin
      push       = emit_close;
      entry.kind = KindClose;
      entry.data = '0;
      started_d  = 1'b0;
      inq_d      = 1'b0;
      esc_d      = 1'b0;
      dead_d     = 1'b0;
      has_d      = 1'b0;
    end else begin
      priority if (is_ctrl && !is_ws) begin
        // drop
      end else if (esc_q) begin
        esc_d = 1'b0;
        has_d = 1'b1;
        push  = 1'b1;
      end else if (in_byte_i == BackslashByte) begin
        esc_d     = 1'b1;
        started_d = 1'b1;
      end else if (in_byte_i == QuoteByte) begin
        started_d = 1'b1;
        if (!inq_q) begin
          inq_d = 1'b1;
        end else begin
          started_d  = 1'b0;
          inq_d      = 1'b0;
          dead_d     = 1'b1;
          has_d      = 1'b0;
          push       = 1'b1;
          entry.kind = KindClose;
          entry.data = '0;
        end
      end else if (is_ws && !inq_q) begin
        dead_d = 1'b0;
        if (started_q) begin
          started_d  = 1'b0;
          push       = emit_close;
          entry.kind = KindClose;
          entry.data = '0;
          has_d      = 1'b0;
        end
      end else if (!is_ws && !inq_q && is_sep) begin
        dead_d            = 1'b0;
        started_d         = 1'b0;
        has_d             = 1'b0;
        push              = 1'b1;
        entry.close_first = emit_close;
        entry.kind        = KindSep;
      end else begin
        if (is_ws || is_sep) begin
          dead_d = 1'b0;
        end
        if (!dead_d) begin
          if (!started_q) begin
            started_d = 1'b1;
            inq_d     = 1'b0;
          end
          has_d = 1'b1;
          push  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      inq_q     <= 1'b0;
      esc_q     <= 1'b0;
      dead_q    <= 1'b0;
      has_q     <= 1'b0;
    end else if (accept) begin
      started_q <= started_d;
      inq_q     <= inq_d;
      esc_q     <= esc_d;
      dead_q    <= dead_d;
      has_q     <= has_d;
    end
  end

  assign push_o       = accept && push;
  assign push_entry_o = entry;

  // An open quote always belongs to a started token
  assert property (@(posedge clk_i) disable iff (!rst_ni) inq_q |-> started_q)
    else $error("open quote without a started token");

endmodule

// ===== rtl/qwss_fifo.sv =====
// ----------------------------------------------------------------------------
// Quoted word splitter queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module qwss_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  qwss_pkg::entry_t        push_entry_i,
  input  logic                    pop_i,
  output qwss_pkg::entry_t        head_o,
  output qwss_pkg::queue_status_t status_o
);
  import qwss_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            slots_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign status_o.full  = (count_q == CntW'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !status_o.full)
    else $error("push into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !status_o.empty)
    else $error("pop from an empty queue");

endmodule

// ===== rtl/qwss_back.sv =====
// ----------------------------------------------------------------------------
// Quoted word splitter back end
// Expands queue entries into one or two results behind an output register.
// ----------------------------------------------------------------------------
module qwss_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  qwss_pkg::entry_t        head_i,
  input  qwss_pkg::queue_status_t q_status_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output qwss_pkg::kind_e         out_kind_o,
  output logic [7:0]              out_byte_o,
  output logic                    out_last_o
);
  import qwss_pkg::*;

  logic       valid_q, valid_d;
  kind_e      kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       phase_q, phase_d;
  logic       load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    kind_d  = kind_q;
    byte_d  = byte_q;
    last_d  = last_q;
    phase_d = phase_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !q_status_i.empty;
      if (head_i.close_first && !phase_q) begin
        // emit the leading close, hold the entry
        kind_d  = KindClose;
        byte_d  = '0;
        last_d  = 1'b0;
        phase_d = !q_status_i.empty;
      end else begin
        kind_d  = head_i.kind;
        byte_d  = head_i.data;
        last_d  = 1'b1;
        phase_d = 1'b0;
        pop_o   = !q_status_i.empty;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  // A half-served entry stays at the head of the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_q |-> !q_status_i.empty)
    else $error("split entry lost from queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_q |-> valid_q && !last_q)
    else $error("split entry without its leading close on the output");

endmodule

// ===== rtl/quoted_word_and_separator_splitter_core.sv =====
// ----------------------------------------------------------------------------
// Quoted word and separator splitter
// Tokenizes a byte stream into append, close and separator results.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle and streams out token results: an
// append of a byte, a close of the current token, or a one-byte separator
// token. Whitespace ends a token, a configured separator ends it and is sent
// as a token of its own, a backslash makes the next byte literal, double
// quotes group text, and a closing quote ends the token and drops the bytes
// that follow until whitespace or a separator. An item with tlast set is the
// end of string: it flushes the pending token and clears all parse state.
// Throughput is one item per cycle while the queue has room; each item gives
// zero, one or two results and the output side moves one result per cycle
// while m_axis_tready is high, so a separator that also closes a token makes
// two output results. A queue of FIFO_DEPTH entries between the classifier
// and the output stage absorbs the extra result, and the input stalls only
// when the queue is full. Results pass the queue, then the output register.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while the
// block is idle; index 0 holds the separator bytes, 1 the count in use and
// 2 the keep-empty flag. Writes to any other index are ignored.
// ----------------------------------------------------------------------------
module quoted_word_and_separator_splitter_core #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_string
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_of_run
);
  import qwss_pkg::*;

  logic          push;
  entry_t        push_entry;
  logic          pop;
  entry_t        head;
  queue_status_t q_status;
  kind_e         out_kind;

  // Front end: classify bytes, track quote, escape and dead-zone state
  qwss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_end_i     (s_axis_tlast),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Queue: hold classified entries so each side stalls on its own
  qwss_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  // Back end: expand each entry into its results, one per cycle while accepted
  qwss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;

endmodule
